### rtl/core/ps2ht_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 host transceiver package
// Shared types, codes and reset constants of the PS/2 host line engine.
// ----------------------------------------------------------------------------
package ps2ht_pkg;

  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned BIT_IDX_W  = 4;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_SEND = 2'd1,
    OP_RECV = 2'd2,
    OP_RSVD = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RELEASE_WAIT  = 3'd0,
    REG_CLOCK_INHIBIT = 3'd1,
    REG_DATA_LEAD     = 3'd2,
    REG_POST_PARITY   = 3'd3,
    REG_RX_RELEASE    = 3'd4,
    REG_START_BIT     = 3'd5
  } cfg_reg_e;

  localparam logic [TICK_W-1:0] RELEASE_WAIT_RST  = 16'd300;
  localparam logic [TICK_W-1:0] CLOCK_INHIBIT_RST = 16'd300;
  localparam logic [TICK_W-1:0] DATA_LEAD_RST     = 16'd10;
  localparam logic [TICK_W-1:0] POST_PARITY_RST   = 16'd50;
  localparam logic [TICK_W-1:0] RX_RELEASE_RST    = 16'd50;
  localparam logic [TICK_W-1:0] START_BIT_RST     = 16'd5;

  typedef struct packed {
    logic [TICK_W-1:0] release_wait;
    logic [TICK_W-1:0] clock_inhibit;
    logic [TICK_W-1:0] data_lead;
    logic [TICK_W-1:0] post_parity;
    logic [TICK_W-1:0] rx_release;
    logic [TICK_W-1:0] start_bit;
  } cfg_t;

  typedef struct packed {
    logic                 clk_line;
    logic                 data_line;
    logic [1:0]           opcode;
    logic [DATA_BITS-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic                 clk_pull_low;
    logic                 data_pull_low;
    logic [DATA_BITS-1:0] rx_byte;
    logic                 rx_valid;
    logic                 tx_done;
    logic                 busy_res;
  } result_t;

endpackage

### rtl/core/ps2ht_cfg_regs.sv
// ----------------------------------------------------------------------------
// PS/2 host timing registers
// Holds the six tick counts that time the line sequences.
// ----------------------------------------------------------------------------
module ps2ht_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ps2ht_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ps2ht_pkg::TICK_W-1:0]        cfg_data_i,
  output ps2ht_pkg::cfg_t                     cfg_o
);

  ps2ht_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ps2ht_pkg::cfg_reg_e'(cfg_index_i))
        ps2ht_pkg::REG_RELEASE_WAIT:  cfg_d.release_wait  = cfg_data_i;
        ps2ht_pkg::REG_CLOCK_INHIBIT: cfg_d.clock_inhibit = cfg_data_i;
        ps2ht_pkg::REG_DATA_LEAD:     cfg_d.data_lead     = cfg_data_i;
        ps2ht_pkg::REG_POST_PARITY:   cfg_d.post_parity   = cfg_data_i;
        ps2ht_pkg::REG_RX_RELEASE:    cfg_d.rx_release    = cfg_data_i;
        ps2ht_pkg::REG_START_BIT:     cfg_d.start_bit     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.release_wait  <= ps2ht_pkg::RELEASE_WAIT_RST;
      cfg_q.clock_inhibit <= ps2ht_pkg::CLOCK_INHIBIT_RST;
      cfg_q.data_lead     <= ps2ht_pkg::DATA_LEAD_RST;
      cfg_q.post_parity   <= ps2ht_pkg::POST_PARITY_RST;
      cfg_q.rx_release    <= ps2ht_pkg::RX_RELEASE_RST;
      cfg_q.start_bit     <= ps2ht_pkg::START_BIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/ps2ht_engine.sv
// ----------------------------------------------------------------------------
// PS/2 host line engine
// Phase machine and shift state; advances one step for each sample taken.
// ----------------------------------------------------------------------------
module ps2ht_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ps2ht_pkg::item_t      item_i,
  input  ps2ht_pkg::cfg_t       cfg_i,
  output ps2ht_pkg::result_t    res_o
);

  typedef enum logic [21:0] {
    PH_IDLE           = 22'h000001,
    PH_TX_REL         = 22'h000002,
    PH_TX_INH         = 22'h000004,
    PH_TX_LEAD        = 22'h000008,
    PH_TX_START_LOW   = 22'h000010,
    PH_TX_BIT_HIGH    = 22'h000020,
    PH_TX_BIT_LOW     = 22'h000040,
    PH_TX_PAR_HIGH    = 22'h000080,
    PH_TX_PAR_LOW     = 22'h000100,
    PH_TX_POST        = 22'h000200,
    PH_TX_ACK_LOW     = 22'h000400,
    PH_TX_IDLE_WAIT   = 22'h000800,
    PH_RX_REL         = 22'h001000,
    PH_RX_START_LOW   = 22'h002000,
    PH_RX_START_DELAY = 22'h004000,
    PH_RX_START_HIGH  = 22'h008000,
    PH_RX_BIT_LOW     = 22'h010000,
    PH_RX_BIT_HIGH    = 22'h020000,
    PH_RX_SKIP1       = 22'h040000,
    PH_RX_SKIP2       = 22'h080000,
    PH_RX_SKIP3       = 22'h100000,
    PH_RX_SKIP4       = 22'h200000
  } phase_e;

  localparam logic [ps2ht_pkg::BIT_IDX_W-1:0] LastBit =
    ps2ht_pkg::BIT_IDX_W'(ps2ht_pkg::DATA_BITS);

  phase_e                               phase_d, phase_q;
  logic [ps2ht_pkg::TICK_W-1:0]         tick_d, tick_q;
  logic [ps2ht_pkg::DATA_BITS-1:0]      shift_d, shift_q;
  logic [ps2ht_pkg::BIT_IDX_W-1:0]      bit_idx_d, bit_idx_q;
  logic                                 parity_d, parity_q;
  logic                                 clk_hold_d, clk_hold_q;
  logic                                 data_hold_d, data_hold_q;
  logic [ps2ht_pkg::DATA_BITS-1:0]      last_rx_d, last_rx_q;

  logic [ps2ht_pkg::TICK_W-1:0]         limit;
  logic [ps2ht_pkg::TICK_W-1:0]         tick_inc;
  logic                                 wait_done;
  logic [ps2ht_pkg::BIT_IDX_W-1:0]      bit_idx_inc;
  logic                                 par_next;
  logic [ps2ht_pkg::DATA_BITS-1:0]      shift_rsh;
  logic                                 rx_valid, tx_done;

  always_comb begin
    case (phase_q)
      PH_TX_REL:         limit = cfg_i.release_wait;
      PH_TX_INH:         limit = cfg_i.clock_inhibit;
      PH_TX_LEAD:        limit = cfg_i.data_lead;
      PH_TX_POST:        limit = cfg_i.post_parity;
      PH_RX_REL:         limit = cfg_i.rx_release;
      PH_RX_START_DELAY: limit = cfg_i.start_bit;
      default:           limit = '0;
    endcase
  end

  // The counter only climbs while below the limit, so the increment never wraps.
  assign tick_inc    = (tick_q < limit) ? tick_q + 1'b1 : tick_q;
  assign wait_done   = (tick_inc >= limit);
  assign bit_idx_inc = bit_idx_q + 1'b1;
  assign par_next    = parity_q ^ shift_q[0];
  assign shift_rsh   = shift_q >> 1;

  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    shift_d     = shift_q;
    bit_idx_d   = bit_idx_q;
    parity_d    = parity_q;
    clk_hold_d  = clk_hold_q;
    data_hold_d = data_hold_q;
    last_rx_d   = last_rx_q;
    rx_valid    = 1'b0;
    tx_done     = 1'b0;
    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (item_i.opcode == ps2ht_pkg::OP_SEND) begin
            shift_d     = item_i.tx_byte;
            parity_d    = 1'b1;
            bit_idx_d   = '0;
            clk_hold_d  = 1'b0;
            data_hold_d = 1'b0;
            tick_d      = '0;
            phase_d     = PH_TX_REL;
          end else if (item_i.opcode == ps2ht_pkg::OP_RECV) begin
            shift_d     = '0;
            bit_idx_d   = '0;
            clk_hold_d  = 1'b0;
            data_hold_d = 1'b0;
            tick_d      = '0;
            phase_d     = PH_RX_REL;
          end
        end
        PH_TX_REL: begin
          tick_d = tick_inc;
          if (wait_done) begin
            clk_hold_d = 1'b1;
            tick_d     = '0;
            phase_d    = PH_TX_INH;
          end
        end
        PH_TX_INH: begin
          tick_d = tick_inc;
          if (wait_done) begin
            data_hold_d = 1'b1;
            tick_d      = '0;
            phase_d     = PH_TX_LEAD;
          end
        end
        PH_TX_LEAD: begin
          tick_d = tick_inc;
          if (wait_done) begin
            clk_hold_d = 1'b0;
            phase_d    = PH_TX_START_LOW;
          end
        end
        PH_TX_START_LOW: begin
          if (!item_i.clk_line) begin
            data_hold_d = ~shift_q[0];
            phase_d     = PH_TX_BIT_HIGH;
          end
        end
        PH_TX_BIT_HIGH: begin
          if (item_i.clk_line) phase_d = PH_TX_BIT_LOW;
        end
        PH_TX_BIT_LOW: begin
          if (!item_i.clk_line) begin
            parity_d  = par_next;
            shift_d   = shift_rsh;
            bit_idx_d = bit_idx_inc;
            if (bit_idx_inc >= LastBit) begin
              data_hold_d = ~par_next;
              phase_d     = PH_TX_PAR_HIGH;
            end else begin
              data_hold_d = ~shift_rsh[0];
              phase_d     = PH_TX_BIT_HIGH;
            end
          end
        end
        PH_TX_PAR_HIGH: begin
          if (item_i.clk_line) phase_d = PH_TX_PAR_LOW;
        end
        PH_TX_PAR_LOW: begin
          if (!item_i.clk_line) begin
            data_hold_d = 1'b0;
            tick_d      = '0;
            phase_d     = PH_TX_POST;
          end
        end
        PH_TX_POST: begin
          tick_d = tick_inc;
          if (wait_done) phase_d = PH_TX_ACK_LOW;
        end
        PH_TX_ACK_LOW: begin
          if (!item_i.clk_line) phase_d = PH_TX_IDLE_WAIT;
        end
        PH_TX_IDLE_WAIT: begin
          if (item_i.clk_line && item_i.data_line) begin
            clk_hold_d = 1'b1;
            tx_done    = 1'b1;
            phase_d    = PH_IDLE;
          end
        end
        PH_RX_REL: begin
          tick_d = tick_inc;
          if (wait_done) phase_d = PH_RX_START_LOW;
        end
        PH_RX_START_LOW: begin
          if (!item_i.clk_line) begin
            tick_d  = '0;
            phase_d = PH_RX_START_DELAY;
          end
        end
        PH_RX_START_DELAY: begin
          tick_d = tick_inc;
          if (wait_done) phase_d = PH_RX_START_HIGH;
        end
        PH_RX_START_HIGH: begin
          if (item_i.clk_line) phase_d = PH_RX_BIT_LOW;
        end
        PH_RX_BIT_LOW: begin
          if (!item_i.clk_line) begin
            shift_d[bit_idx_q[2:0]] = item_i.data_line;
            phase_d                 = PH_RX_BIT_HIGH;
          end
        end
        PH_RX_BIT_HIGH: begin
          if (item_i.clk_line) begin
            bit_idx_d = bit_idx_inc;
            phase_d   = (bit_idx_inc >= LastBit) ? PH_RX_SKIP1 : PH_RX_BIT_LOW;
          end
        end
        PH_RX_SKIP1: begin
          if (!item_i.clk_line) phase_d = PH_RX_SKIP2;
        end
        PH_RX_SKIP2: begin
          if (item_i.clk_line) phase_d = PH_RX_SKIP3;
        end
        PH_RX_SKIP3: begin
          if (!item_i.clk_line) phase_d = PH_RX_SKIP4;
        end
        PH_RX_SKIP4: begin
          if (item_i.clk_line) begin
            clk_hold_d = 1'b1;
            last_rx_d  = shift_q;
            rx_valid   = 1'b1;
            phase_d    = PH_IDLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      shift_q     <= '0;
      bit_idx_q   <= '0;
      parity_q    <= 1'b1;
      clk_hold_q  <= 1'b0;
      data_hold_q <= 1'b0;
      last_rx_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      tick_q      <= tick_d;
      shift_q     <= shift_d;
      bit_idx_q   <= bit_idx_d;
      parity_q    <= parity_d;
      clk_hold_q  <= clk_hold_d;
      data_hold_q <= data_hold_d;
      last_rx_q   <= last_rx_d;
    end
  end

  assign res_o.clk_pull_low  = clk_hold_d;
  assign res_o.data_pull_low = data_hold_d;
  assign res_o.rx_byte       = last_rx_d;
  assign res_o.rx_valid      = rx_valid;
  assign res_o.tx_done       = tx_done;
  assign res_o.busy_res      = (phase_d != PH_IDLE);

endmodule

### rtl/core/ps2_host_transceiver.sv
// ----------------------------------------------------------------------------
// PS/2 host transceiver
// Host side line engine for a PS/2 port, stepped once per sampled tick.
// ----------------------------------------------------------------------------
// Each request on the input channel is one tick: the sampled clock and data
// levels plus a command (none, send a byte, receive a byte). Commands are
// only taken while the engine is idle. Every request yields exactly one
// result on the output channel: the line drive levels, the last received
// byte, one-tick receive and send strobes and a busy flag.
// A request is captured in an input register, stepped through the phase
// machine once the output register is free, and lands in the output
// register. One request is taken per cycle while the output is not
// stalled; each request advances the phase machine by one step.
// When the receiver stalls, the output register holds its result and the
// input register fills; the input stall rises only when both are full.
// Reset clears the engine line holds, returns it to idle and loads the timing
// registers with their default tick counts. The user writes timing registers
// through the configuration port while no request is in flight (not enforced).
// ----------------------------------------------------------------------------
module ps2_host_transceiver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ps2ht_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ps2ht_pkg::TICK_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                clk_line_i,
  input  logic                                data_line_i,
  input  logic [1:0]                          opcode_i,
  input  logic [ps2ht_pkg::DATA_BITS-1:0]     tx_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                clk_pull_low_o,
  output logic                                data_pull_low_o,
  output logic [ps2ht_pkg::DATA_BITS-1:0]     rx_byte_o,
  output logic                                rx_valid_o,
  output logic                                tx_done_o,
  output logic                                busy_res_o
);

  ps2ht_pkg::cfg_t    cfg;
  ps2ht_pkg::item_t   item_q;
  ps2ht_pkg::result_t res_step, res_q;
  logic               in_vld_q, out_vld_q;
  logic               out_free, step, in_take;

  ps2ht_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  ps2ht_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.clk_line  <= clk_line_i;
      item_q.data_line <= data_line_i;
      item_q.opcode    <= opcode_i;
      item_q.tx_byte   <= tx_byte_i;
    end
    if (step) begin
      res_q <= res_step;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign clk_pull_low_o  = res_q.clk_pull_low;
  assign data_pull_low_o = res_q.data_pull_low;
  assign rx_byte_o       = res_q.rx_byte;
  assign rx_valid_o      = res_q.rx_valid;
  assign tx_done_o       = res_q.tx_done;
  assign busy_res_o      = res_q.busy_res;

`ifndef ASSERT_OFF
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(res_q.rx_valid && res_q.tx_done))
    else $error("receive and send strobes raised on the same tick");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.rx_valid || res_q.tx_done) |->
      !res_q.busy_res && res_q.clk_pull_low)
    else $error("transfer finished without idling and holding clock low");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("stepped request produced no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && out_stall_i |=> in_vld_q && $stable(item_q))
    else $error("pending request lost while output stalled");
`endif

endmodule

### tb/sv/ps2_host_transceiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 host transceiver testbench
// A device model answers the host on the sampled clock and data lines, and a
// line engine predictor tracks every accepted request and checks each result
// field by field. The run covers the reset timing, all-zero timing and
// several random settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module ps2_host_transceiver_test;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [ps2ht_pkg::BIT_IDX_W-1:0] LAST_BIT =
    ps2ht_pkg::BIT_IDX_W'(ps2ht_pkg::DATA_BITS);

  typedef enum logic [4:0] {
    S_IDLE, S_TX_RELEASE, S_TX_INHIBIT, S_TX_LEAD, S_TX_START,
    S_TX_BIT_HI, S_TX_BIT_LO, S_TX_PAR_HI, S_TX_PAR_LO,
    S_TX_POST, S_TX_ACK, S_TX_SETTLE,
    S_RX_RELEASE, S_RX_START, S_RX_START_DLY, S_RX_START_HI,
    S_RX_BIT_LO, S_RX_BIT_HI,
    S_RX_PAR_LO, S_RX_PAR_HI, S_RX_STOP_LO, S_RX_STOP_HI
  } line_phase_e;

  class ps2ht_scoreboard;
    ps2ht_pkg::cfg_t                 timing;
    line_phase_e                     phase;
    logic [ps2ht_pkg::TICK_W-1:0]    ticks;
    logic [ps2ht_pkg::DATA_BITS-1:0] shifter;
    logic [ps2ht_pkg::BIT_IDX_W-1:0] bit_cnt;
    logic                            parity;
    logic                            clk_low;
    logic                            dat_low;
    logic [ps2ht_pkg::DATA_BITS-1:0] rx_last;
    ps2ht_pkg::result_t              expected_q[$];
    int                              errors;

    function new();
      errors = 0;
      timing.release_wait  = ps2ht_pkg::RELEASE_WAIT_RST;
      timing.clock_inhibit = ps2ht_pkg::CLOCK_INHIBIT_RST;
      timing.data_lead     = ps2ht_pkg::DATA_LEAD_RST;
      timing.post_parity   = ps2ht_pkg::POST_PARITY_RST;
      timing.rx_release    = ps2ht_pkg::RX_RELEASE_RST;
      timing.start_bit     = ps2ht_pkg::START_BIT_RST;
      phase   = S_IDLE;
      ticks   = '0;
      shifter = '0;
      bit_cnt = '0;
      parity  = 1'b1;
      clk_low = 1'b0;
      dat_low = 1'b0;
      rx_last = '0;
    endfunction

    function void write_reg(ps2ht_pkg::cfg_reg_e idx, logic [ps2ht_pkg::TICK_W-1:0] value);
      case (idx)
        ps2ht_pkg::REG_RELEASE_WAIT:  timing.release_wait  = value;
        ps2ht_pkg::REG_CLOCK_INHIBIT: timing.clock_inhibit = value;
        ps2ht_pkg::REG_DATA_LEAD:     timing.data_lead     = value;
        ps2ht_pkg::REG_POST_PARITY:   timing.post_parity   = value;
        ps2ht_pkg::REG_RX_RELEASE:    timing.rx_release    = value;
        ps2ht_pkg::REG_START_BIT:     timing.start_bit     = value;
        default: ;
      endcase
    endfunction

    function bit timer_done(logic [ps2ht_pkg::TICK_W-1:0] lim);
      if (ticks < lim) ticks = ticks + 1'b1;
      return ticks >= lim;
    endfunction

    function void note_request(ps2ht_pkg::item_t it);
      ps2ht_pkg::result_t r;
      logic               rx_strobe;
      logic               tx_strobe;
      rx_strobe = 1'b0;
      tx_strobe = 1'b0;
      case (phase)
        S_IDLE: begin
          if (it.opcode == ps2ht_pkg::OP_SEND) begin
            shifter = it.tx_byte;
            parity  = 1'b1;
            bit_cnt = '0;
            clk_low = 1'b0;
            dat_low = 1'b0;
            phase   = S_TX_RELEASE;
            ticks   = '0;
          end else if (it.opcode == ps2ht_pkg::OP_RECV) begin
            shifter = '0;
            bit_cnt = '0;
            clk_low = 1'b0;
            dat_low = 1'b0;
            phase   = S_RX_RELEASE;
            ticks   = '0;
          end
        end
        S_TX_RELEASE: begin
          if (timer_done(timing.release_wait)) begin
            clk_low = 1'b1;
            phase   = S_TX_INHIBIT;
            ticks   = '0;
          end
        end
        S_TX_INHIBIT: begin
          if (timer_done(timing.clock_inhibit)) begin
            dat_low = 1'b1;
            phase   = S_TX_LEAD;
            ticks   = '0;
          end
        end
        S_TX_LEAD: begin
          if (timer_done(timing.data_lead)) begin
            clk_low = 1'b0;
            phase   = S_TX_START;
          end
        end
        S_TX_START: begin
          if (!it.clk_line) begin
            dat_low = ~shifter[0];
            phase   = S_TX_BIT_HI;
          end
        end
        S_TX_BIT_HI: if (it.clk_line) phase = S_TX_BIT_LO;
        S_TX_BIT_LO: begin
          if (!it.clk_line) begin
            parity  = parity ^ shifter[0];
            shifter = shifter >> 1;
            bit_cnt = bit_cnt + 1'b1;
            if (bit_cnt >= LAST_BIT) begin
              dat_low = ~parity;
              phase   = S_TX_PAR_HI;
            end else begin
              dat_low = ~shifter[0];
              phase   = S_TX_BIT_HI;
            end
          end
        end
        S_TX_PAR_HI: if (it.clk_line) phase = S_TX_PAR_LO;
        S_TX_PAR_LO: begin
          if (!it.clk_line) begin
            dat_low = 1'b0;
            phase   = S_TX_POST;
            ticks   = '0;
          end
        end
        S_TX_POST: if (timer_done(timing.post_parity)) phase = S_TX_ACK;
        S_TX_ACK: if (!it.clk_line) phase = S_TX_SETTLE;
        S_TX_SETTLE: begin
          if (it.clk_line && it.data_line) begin
            clk_low   = 1'b1;
            tx_strobe = 1'b1;
            phase     = S_IDLE;
          end
        end
        S_RX_RELEASE: if (timer_done(timing.rx_release)) phase = S_RX_START;
        S_RX_START: begin
          if (!it.clk_line) begin
            phase = S_RX_START_DLY;
            ticks = '0;
          end
        end
        S_RX_START_DLY: if (timer_done(timing.start_bit)) phase = S_RX_START_HI;
        S_RX_START_HI: if (it.clk_line) phase = S_RX_BIT_LO;
        S_RX_BIT_LO: begin
          if (!it.clk_line) begin
            shifter[bit_cnt[2:0]] = it.data_line;
            phase = S_RX_BIT_HI;
          end
        end
        S_RX_BIT_HI: begin
          if (it.clk_line) begin
            bit_cnt = bit_cnt + 1'b1;
            phase   = (bit_cnt >= LAST_BIT) ? S_RX_PAR_LO : S_RX_BIT_LO;
          end
        end
        S_RX_PAR_LO: if (!it.clk_line) phase = S_RX_PAR_HI;
        S_RX_PAR_HI: if (it.clk_line) phase = S_RX_STOP_LO;
        S_RX_STOP_LO: if (!it.clk_line) phase = S_RX_STOP_HI;
        S_RX_STOP_HI: begin
          if (it.clk_line) begin
            clk_low   = 1'b1;
            rx_last   = shifter;
            rx_strobe = 1'b1;
            phase     = S_IDLE;
          end
        end
        default: phase = S_IDLE;
      endcase
      r.clk_pull_low  = clk_low;
      r.data_pull_low = dat_low;
      r.rx_byte       = rx_last;
      r.rx_valid      = rx_strobe;
      r.tx_done       = tx_strobe;
      r.busy_res      = (phase != S_IDLE);
      expected_q.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s mismatch: expected %0h, actual %0h", field, want, seen);
        errors++;
      end
    endfunction

    function void check_result(ps2ht_pkg::result_t got);
      ps2ht_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("clk_pull_low", 32'(want.clk_pull_low), 32'(got.clk_pull_low));
      compare("data_pull_low", 32'(want.data_pull_low), 32'(got.data_pull_low));
      compare("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
      compare("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
      compare("tx_done", 32'(want.tx_done), 32'(got.tx_done));
      compare("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    endfunction
  endclass

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [ps2ht_pkg::CFG_IDX_W-1:0] cfg_index_i = ps2ht_pkg::REG_RELEASE_WAIT;
  logic [ps2ht_pkg::TICK_W-1:0]    cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic                            clk_line_i  = 1'b1;
  logic                            data_line_i = 1'b1;
  logic [1:0]                      opcode_i    = ps2ht_pkg::OP_NONE;
  logic [ps2ht_pkg::DATA_BITS-1:0] tx_byte_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            clk_pull_low_o;
  logic                            data_pull_low_o;
  logic [ps2ht_pkg::DATA_BITS-1:0] rx_byte_o;
  logic                            rx_valid_o;
  logic                            tx_done_o;
  logic                            busy_res_o;

  ps2ht_scoreboard sb;
  bit              calm = 1'b0;
  bit              dev_clk = 1'b1;
  bit              dev_dat = 1'b1;
  int unsigned     dev_wait = 0;
  int unsigned     idle_cycles = 0;

  ps2_host_transceiver dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .clk_line_i      (clk_line_i),
    .data_line_i     (data_line_i),
    .opcode_i        (opcode_i),
    .tx_byte_i       (tx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .clk_pull_low_o  (clk_pull_low_o),
    .data_pull_low_o (data_pull_low_o),
    .rx_byte_o       (rx_byte_o),
    .rx_valid_o      (rx_valid_o),
    .tx_done_o       (tx_done_o),
    .busy_res_o      (busy_res_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk_i) begin
    ps2ht_pkg::result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.clk_pull_low  = clk_pull_low_o;
      got.data_pull_low = data_pull_low_o;
      got.rx_byte       = rx_byte_o;
      got.rx_valid      = rx_valid_o;
      got.tx_done       = tx_done_o;
      got.busy_res      = busy_res_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic drive_tick(input ps2ht_pkg::item_t it);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    clk_line_i  <= it.clk_line;
    data_line_i <= it.data_line;
    opcode_i    <= it.opcode;
    tx_byte_i   <= it.tx_byte;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(it);
  endtask

  // The device toggles its clock with a random half period and changes data
  // while its clock is high; now and then it goes quiet for a long stretch.
  task automatic device_tick(input ps2ht_pkg::opcode_e op,
                             input logic [ps2ht_pkg::DATA_BITS-1:0] b);
    ps2ht_pkg::item_t it;
    if (dev_wait == 0) begin
      dev_clk = ~dev_clk;
      if (dev_clk) dev_dat = 1'($urandom_range(0, 1));
      dev_wait = ($urandom_range(0, 49) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end else begin
      dev_wait--;
    end
    it.clk_line  = dev_clk;
    it.data_line = dev_dat;
    it.opcode    = op;
    it.tx_byte   = b;
    drive_tick(it);
  endtask

  function automatic ps2ht_pkg::opcode_e pick_op();
    int unsigned r;
    if (sb.phase != S_IDLE) return ps2ht_pkg::opcode_e'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 40) return ps2ht_pkg::OP_SEND;
    if (r < 80) return ps2ht_pkg::OP_RECV;
    if (r < 90) return ps2ht_pkg::OP_NONE;
    return ps2ht_pkg::OP_RSVD;
  endfunction

  task automatic run_command(input ps2ht_pkg::opcode_e op,
                             input logic [ps2ht_pkg::DATA_BITS-1:0] b);
    device_tick(op, b);
    while (sb.phase != S_IDLE) begin
      device_tick(ps2ht_pkg::opcode_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task automatic drain();
    while (sb.phase != S_IDLE) begin
      device_tick(ps2ht_pkg::opcode_e'($urandom_range(0, 3)), 8'($urandom));
    end
    hold_until_drained();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [ps2ht_pkg::TICK_W-1:0] vals [6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= ps2ht_pkg::cfg_reg_e'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      sb.write_reg(ps2ht_pkg::cfg_reg_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) hold_until_drained();
      device_tick(pick_op(), 8'($urandom));
    end
  endtask

  initial begin
    logic [ps2ht_pkg::TICK_W-1:0] vals [6];
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_command(ps2ht_pkg::OP_SEND, 8'hA5);
    run_command(ps2ht_pkg::OP_RECV, 8'h00);
    drain();

    vals = '{default: 16'h0000};
    apply_config(vals);
    run_command(ps2ht_pkg::OP_SEND, 8'h00);
    run_command(ps2ht_pkg::OP_SEND, 8'hFF);
    run_command(ps2ht_pkg::OP_RECV, 8'h3C);
    run_command(ps2ht_pkg::OP_RSVD, 8'hFF);
    run_command(ps2ht_pkg::OP_NONE, 8'h55);
    dev_wait = 80;
    run_command(ps2ht_pkg::OP_RECV, 8'h00);
    dev_wait = 80;
    run_command(ps2ht_pkg::OP_SEND, 8'h96);
    drain();

    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < 6; i++) begin
        vals[i] = ps2ht_pkg::TICK_W'(($urandom_range(0, 5) == 0) ?
                                     $urandom_range(0, 40) : $urandom_range(0, 3));
      end
      apply_config(vals);
      calm = (p == 1);
      run_random((p == 1) ? 120 : 60);
      drain();
    end
    calm = 1'b0;

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
